// ===== hdl/ssl_pkg.sv =====
// Package for the segment split / longest gap block.
// Holds sizes, payload structs, codes and the control structs shared by
// the cell chain, the gap scanner and the top level.
package ssl_pkg;

   // Sizes
   localparam int CAPACITY    = 1024;
   localparam int POS_BITS    = 32;
   localparam int CNT_BITS    = $clog2(CAPACITY + 1);
   localparam int STATUS_BITS = 2;

   typedef logic [POS_BITS-1:0]    pos_type;
   typedef logic [CNT_BITS-1:0]    count_type;
   typedef logic [STATUS_BITS-1:0] status_type;

   // Line length after reset
   localparam pos_type LINE_RESET = POS_BITS'(65535);

   // Request modes
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_CLEAR  = 1'b1;

   // Response status codes
   localparam status_type STATUS_OK     = 2'd0;
   localparam status_type STATUS_REJECT = 2'd1;
   localparam status_type STATUS_FULL   = 2'd2;

   // Request and response payloads
   typedef struct packed {
      logic    mode;
      pos_type position;
   } req_type;

   typedef struct packed {
      pos_type    longest_gap;
      status_type status;
      count_type  points_stored;
   } rsp_type;

   // Cell chain control
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_ROTATE,
      CELL_INSERT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      count_type   count;
      pos_type     pos;
      pos_type     head;
   } cell_ctrl_type;

   // Gap scanner control and result
   typedef struct packed {
      logic    start;
      logic    step;
      pos_type pos;
      pos_type value;
   } scan_ctrl_type;

   typedef struct packed {
      logic    dup;
      pos_type max_keep;
      pos_type max_split;
   } scan_result_type;

   // Top level sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/segment_split_longest_gap.sv =====
// Segment split / longest gap: a line from zero to csr line length, cut at a
// sorted set of points held in a chain of cells. For an insert request the
// stored points rotate once through the chain head, one per cycle, while the
// gap scanner checks for a duplicate and tracks the longest gap with and
// without the new cut; a step for the tail segment follows, then the
// commit, which registers the response. A clear request goes straight
// from acceptance to the commit. The next request is accepted the cycle
// after the commit. One request is in flight at a time; the response
// register lets the next request enter while a response waits.
// Writing the line length empties the store.
// Depends on ssl_pkg, ssl_cell and ssl_gap_scan.
module segment_split_longest_gap (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_ready,
   input  ssl_pkg::req_type req_data,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ssl_pkg::rsp_type rsp_data,
   // line length register
   input  logic             csr_wr_en,
   input  logic [31:0]      csr_wr_data
);

   ssl_pkg::state_type state_ff, state_in;
   ssl_pkg::pos_type   line_length_ff;
   ssl_pkg::count_type count_ff, count_in;
   ssl_pkg::count_type step_ff, step_in;
   ssl_pkg::pos_type   pos_ff;
   logic               mode_ff;
   logic               rsp_valid_ff;
   ssl_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic accept;
   logic last_step;
   logic out_free;
   logic commit;
   logic insert_ok;
   logic out_of_range;

   ssl_pkg::cell_ctrl_type   cell_ctrl;
   ssl_pkg::scan_ctrl_type   scan_ctrl;
   ssl_pkg::scan_result_type scan_result;

   ssl_pkg::pos_type cell_value   [ssl_pkg::CAPACITY];
   logic             cell_greater [ssl_pkg::CAPACITY];

   assign accept    = req_valid && req_ready;
   assign last_step = step_ff == count_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssl_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_data.mode == ssl_pkg::MODE_CLEAR) ?
                          ssl_pkg::ST_DONE : ssl_pkg::ST_SCAN;
            end
         end
         ssl_pkg::ST_SCAN: begin
            if (last_step) begin
               state_in = ssl_pkg::ST_DONE;
            end
         end
         ssl_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = ssl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ssl_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready       = 1'b0;
      commit          = 1'b0;
      scan_ctrl.start = accept;
      scan_ctrl.step  = 1'b0;
      scan_ctrl.pos   = pos_ff;
      scan_ctrl.value = last_step ? line_length_ff : cell_value[0];
      cell_ctrl.op    = ssl_pkg::CELL_HOLD;
      cell_ctrl.count = count_ff;
      cell_ctrl.pos   = pos_ff;
      cell_ctrl.head  = cell_value[0];
      case (state_ff)
         ssl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         ssl_pkg::ST_SCAN: begin
            scan_ctrl.step = 1'b1;
            if (!last_step) begin
               cell_ctrl.op = ssl_pkg::CELL_ROTATE;
            end
         end
         ssl_pkg::ST_DONE: begin
            commit = out_free;
            if (out_free && insert_ok) begin
               cell_ctrl.op = ssl_pkg::CELL_INSERT;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Outcome of an insert or a clear, and the response
   always_comb begin
      out_of_range = (pos_ff == '0) || (pos_ff >= line_length_ff);
      insert_ok    = 1'b0;
      count_in     = count_ff;
      rsp_data_in  = '0;
      if (mode_ff == ssl_pkg::MODE_CLEAR) begin
         count_in                = '0;
         rsp_data_in.longest_gap = line_length_ff;
         rsp_data_in.status      = ssl_pkg::STATUS_OK;
      end else if (out_of_range || scan_result.dup) begin
         rsp_data_in.longest_gap = scan_result.max_keep;
         rsp_data_in.status      = ssl_pkg::STATUS_REJECT;
      end else if (count_ff == ssl_pkg::count_type'(ssl_pkg::CAPACITY)) begin
         rsp_data_in.longest_gap = scan_result.max_keep;
         rsp_data_in.status      = ssl_pkg::STATUS_FULL;
      end else begin
         insert_ok               = 1'b1;
         count_in                = count_ff + 1'b1;
         rsp_data_in.longest_gap = scan_result.max_split;
         rsp_data_in.status      = ssl_pkg::STATUS_OK;
      end
      rsp_data_in.points_stored = count_in;
   end

   // Scan step counter
   always_comb begin
      step_in = step_ff;
      if (accept) begin
         step_in = '0;
      end else if ((state_ff == ssl_pkg::ST_SCAN) && !last_step) begin
         step_in = step_ff + 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ssl_pkg::ST_IDLE;
         line_length_ff <= ssl_pkg::LINE_RESET;
         count_ff       <= '0;
         step_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (csr_wr_en) begin
            line_length_ff <= csr_wr_data;
            count_ff       <= '0;
         end else if (commit) begin
            count_ff <= count_in;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         pos_ff  <= req_data.position;
         mode_ff <= req_data.mode;
      end
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Chain of cells
   for (genvar i = 0; i < ssl_pkg::CAPACITY; i++) begin : g_cell
      ssl_pkg::pos_type left_value;
      logic             left_greater;
      ssl_pkg::pos_type right_value;

      if (i == 0) begin : g_first
         assign left_value   = '0;
         assign left_greater = 1'b0;
      end else begin : g_inner_left
         assign left_value   = cell_value[i-1];
         assign left_greater = cell_greater[i-1];
      end

      if (i == ssl_pkg::CAPACITY - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_inner_right
         assign right_value = cell_value[i+1];
      end

      ssl_cell u_cell (
         .clock        (clock),
         .cell_index   (ssl_pkg::count_type'(i)),
         .ctrl         (cell_ctrl),
         .left_value   (left_value),
         .left_greater (left_greater),
         .right_value  (right_value),
         .value        (cell_value[i]),
         .greater      (cell_greater[i])
      );
   end

   // Gap scanner at the chain head
   ssl_gap_scan u_gap_scan (
      .clock  (clock),
      .ctrl   (scan_ctrl),
      .result (scan_result)
   );

endmodule

// ===== hdl/ssl_cell.sv =====
// One cell of the sorted cut point chain: holds one point.
// Rotates toward cell 0 during a scan, shifts right on insert.
// Depends on ssl_pkg.
module ssl_cell (
   input  logic                  clock,
   input  ssl_pkg::count_type    cell_index,
   input  ssl_pkg::cell_ctrl_type ctrl,
   input  ssl_pkg::pos_type      left_value,
   input  logic                  left_greater,
   input  ssl_pkg::pos_type      right_value,
   output ssl_pkg::pos_type      value,
   output logic                  greater
);

   ssl_pkg::pos_type value_ff;
   ssl_pkg::pos_type value_in;
   logic             valid;

   // Point is live below the fill count; compare against the new position
   always_comb begin
      valid   = cell_index < ctrl.count;
      greater = valid && (value_ff > ctrl.pos);
   end

   // Next value
   always_comb begin
      value_in = value_ff;
      case (ctrl.op)
         ssl_pkg::CELL_HOLD: begin
            value_in = value_ff;
         end
         ssl_pkg::CELL_ROTATE: begin
            // last live cell wraps around to the head
            if (cell_index == ssl_pkg::count_type'(ctrl.count - 1'b1)) begin
               value_in = ctrl.head;
            end else begin
               value_in = right_value;
            end
         end
         ssl_pkg::CELL_INSERT: begin
            if (greater || (cell_index == ctrl.count)) begin
               value_in = left_greater ? left_value : ctrl.pos;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== hdl/ssl_gap_scan.sv =====
// Gap scanner at the head of the chain: takes one point per cycle, while
// step is set, in ascending order and tracks the largest gap with and
// without the new cut. Depends on ssl_pkg.
module ssl_gap_scan (
   input  logic                    clock,
   input  ssl_pkg::scan_ctrl_type  ctrl,
   output ssl_pkg::scan_result_type result
);

   ssl_pkg::pos_type prev_ff,  prev_in;
   ssl_pkg::pos_type keep_ff,  keep_in;
   ssl_pkg::pos_type split_ff, split_in;
   logic             dup_ff,   dup_in;

   ssl_pkg::pos_type gap_whole;
   ssl_pkg::pos_type gap_lo;
   ssl_pkg::pos_type gap_hi;
   ssl_pkg::pos_type cand_a;
   ssl_pkg::pos_type cand_b;
   ssl_pkg::pos_type split_mid;
   logic             splits;

   // Gap candidates for this step
   always_comb begin
      gap_whole = ctrl.value - prev_ff;
      gap_lo    = ctrl.pos - prev_ff;
      gap_hi    = ctrl.value - ctrl.pos;
      splits    = (prev_ff < ctrl.pos) && (ctrl.pos < ctrl.value);
      cand_a    = splits ? gap_lo : gap_whole;
      cand_b    = splits ? gap_hi : gap_whole;
      split_mid = (split_ff > cand_a) ? split_ff : cand_a;
   end

   // Accumulators
   always_comb begin
      prev_in  = prev_ff;
      keep_in  = keep_ff;
      split_in = split_ff;
      dup_in   = dup_ff;
      if (ctrl.start) begin
         prev_in  = '0;
         keep_in  = '0;
         split_in = '0;
         dup_in   = 1'b0;
      end else if (ctrl.step) begin
         prev_in  = ctrl.value;
         keep_in  = (keep_ff > gap_whole) ? keep_ff : gap_whole;
         split_in = (split_mid > cand_b) ? split_mid : cand_b;
         dup_in   = dup_ff || (ctrl.value == ctrl.pos);
      end
   end

   always_ff @(posedge clock) begin
      prev_ff  <= prev_in;
      keep_ff  <= keep_in;
      split_ff <= split_in;
      dup_ff   <= dup_in;
   end

   // dup, max_keep, max_split
   assign result = {dup_ff, keep_ff, split_ff};

endmodule
